// ===== rtl/qudn_pkg.sv =====
// qudn_pkg: shared widths, constants and beat types for the quaternion
// dequantize/normalize pipeline. No dependencies.
`default_nettype none

package qudn_pkg;

  localparam int CODE_W     = 16;              // unorm16 input code
  localparam int UNIT_W     = 16;              // Q1.15 result
  localparam int LANES      = 4;               // x, y, z, w
  localparam int MAG_W      = 16;              // |2u - 65535|, always odd
  localparam int SQ_W       = 2 * MAG_W;       // mag squared
  localparam int S_W        = SQ_W + 2;        // sum of four squares
  localparam int N_W        = 16;              // result magnitude 0..32768
  localparam int CELL_COUNT = N_W;             // one cell per result bit
  localparam int BIT_W      = $clog2(CELL_COUNT);
  localparam int Q_W        = S_W + N_W + 2;   // signed (2n-1)*S
  localparam int D_W        = SQ_W + 32 + 6;   // signed residual T - (2n-1)^2*S
  localparam int TDATA_W    = LANES * CODE_W;

  localparam logic [UNIT_W-1:0] UNIT_MAX = {1'b0, {(UNIT_W-1){1'b1}}};

  // one lane of the running restoring search
  typedef struct packed {
    logic                  neg;
    logic [N_W-1:0]        n;
    logic signed [Q_W-1:0] q;
    logic signed [D_W-1:0] d;
  } lane_t;

  typedef struct packed {
    logic [S_W-1:0]          s;
    lane_t [LANES-1:0]       lane;
  } work_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } dec_t;

endpackage

`default_nettype wire

// ===== rtl/qudn_front.sv =====
// qudn_front: decode four unorm16 codes, square them, sum and seed the
// search lanes. Three registered stages. Depends on qudn_pkg.
`default_nettype none

module qudn_front import qudn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [TDATA_W-1:0]  in_codes,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      work_t               out_data
);

  logic                          v1, v2, v3;
  logic                          rdy1, rdy2, rdy3;
  dec_t        [LANES-1:0]       dec;
  dec_t        [LANES-1:0]       dec_next;
  logic        [LANES-1:0]       neg2;
  logic        [LANES-1:0][SQ_W-1:0] sq;
  logic        [S_W-1:0]         sum_next;
  work_t                         work_next;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v3;

  // v = 2u - 65535: magnitude is the low 15 bits (inverted when negative)
  // with a 1 appended
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dec_next[i].neg = ~in_codes[i*CODE_W + CODE_W - 1];
      dec_next[i].mag = in_codes[i*CODE_W + CODE_W - 1]
                      ? {in_codes[i*CODE_W +: CODE_W-1], 1'b1}
                      : {~in_codes[i*CODE_W +: CODE_W-1], 1'b1};
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_next = sum_next + S_W'(sq[i]);
    end
    work_next.s = sum_next;
    for (int i = 0; i < LANES; i++) begin
      work_next.lane[i].neg = neg2[i];
      work_next.lane[i].n   = '0;
      // n = 0 stands for 2n-1 = -1: Q = -S, D = mag^2 * 2^32 - S
      work_next.lane[i].q   = -signed'(Q_W'(sum_next));
      work_next.lane[i].d   = signed'(D_W'({sq[i], 32'd0})) - signed'(D_W'(sum_next));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) dec <= dec_next;
    if (v1 && rdy2) begin
      for (int i = 0; i < LANES; i++) begin
        sq[i]   <= dec[i].mag * dec[i].mag;
        neg2[i] <= dec[i].neg;
      end
    end
    if (v2 && rdy3) out_data <= work_next;
  end

endmodule

`default_nettype wire

// ===== rtl/qudn_cell.sv =====
// qudn_cell: one bit of the restoring search for all four lanes, one
// registered beat. Depends on qudn_pkg.
`default_nettype none

module qudn_cell import qudn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [BIT_W-1:0] bit_pos,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire work_t            in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      work_t            out_data
);

  logic                  valid;
  work_t                 data_next;
  logic signed [Q_W-1:0] s_q;
  logic signed [Q_W-1:0] e;
  logic signed [D_W-1:0] cand;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Try n + 2^b: P grows by (Q + S*2^b) * 2^(b+2); keep it when the
  // residual stays non-negative.
  always_comb begin
    data_next = in_data;
    s_q       = signed'(Q_W'(in_data.s));
    e         = '0;
    cand      = '0;
    for (int i = 0; i < LANES; i++) begin
      e    = in_data.lane[i].q + (s_q <<< bit_pos);
      cand = in_data.lane[i].d - (D_W'(e) <<< (bit_pos + 2));
      if (!cand[D_W-1]) begin
        data_next.lane[i].d = cand;
        data_next.lane[i].q = in_data.lane[i].q + (s_q <<< (bit_pos + 1));
        data_next.lane[i].n = in_data.lane[i].n | (N_W'(1) << bit_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= data_next;
  end

endmodule

`default_nettype wire

// ===== rtl/qudn_out.sv =====
// qudn_out: applies signs, saturates +1.0 and holds the output beat.
// Depends on qudn_pkg.
`default_nettype none

module qudn_out import qudn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire work_t              in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [TDATA_W-1:0] out_units
);

  logic               valid;
  logic [TDATA_W-1:0] units_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (in_data.lane[i].neg) begin
        units_next[i*UNIT_W +: UNIT_W] = UNIT_W'(~in_data.lane[i].n + N_W'(1));
      end else if (in_data.lane[i].n > N_W'(UNIT_MAX)) begin
        units_next[i*UNIT_W +: UNIT_W] = UNIT_MAX;
      end else begin
        units_next[i*UNIT_W +: UNIT_W] = UNIT_W'(in_data.lane[i].n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_units <= units_next;
  end

endmodule

`default_nettype wire

// ===== rtl/quat_unorm16_dequant_normalize.sv =====
// quat_unorm16_dequant_normalize: top level, front stages, a row of
// 16 search cells and the output register. Depends on qudn_pkg,
// qudn_front, qudn_cell, qudn_out.
//
//  channel | dir | tdata fields (low bit up)               | tuser/tlast
//  s_axis  | in  | code_x, code_y, code_z, code_w (16 each) | none
//  m_axis  | out | unit_x, unit_y, unit_z, unit_w (16 each) | none
//
// One beat per clock sustained while m_axis_tready holds high; from input
// accept to m_axis_tvalid a beat passes decode, square, sum/seed, 16 cells
// (one result bit each, MSB first) and the output register.
// rst (synchronous, high) clears the valid bits only; data is unreset.
// Each stage moves whenever its successor is empty or moving, so bubbles
// collapse and s_axis_tready stays high while the pipe has room even if
// m_axis is stalled.
`default_nettype none

module quat_unorm16_dequant_normalize import qudn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,  // code_x, code_y, code_z, code_w
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [TDATA_W-1:0] m_axis_tdata   // unit_x, unit_y, unit_z, unit_w
);

  // chain index 0 is the front output; index CELL_COUNT the last cell
  logic  [CELL_COUNT:0] chain_valid;
  logic  [CELL_COUNT:0] chain_ready;
  work_t [CELL_COUNT:0] chain_data;

  qudn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_codes  (s_axis_tdata),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // cell g resolves result bit CELL_COUNT-1-g
  for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
    qudn_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bit_pos   (BIT_W'(CELL_COUNT - 1 - g)),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  qudn_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[CELL_COUNT]),
    .in_ready  (chain_ready[CELL_COUNT]),
    .in_data   (chain_data[CELL_COUNT]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_units (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/quat_unorm16_dequant_normalize_tb.sv =====
`timescale 1ns / 1ps
// quat_unorm16_dequant_normalize_tb: self-checking bench for the unorm16 quaternion
// dequantize/normalize block. Needs qudn_pkg and the block's RTL only.

module quat_unorm16_dequant_normalize_tb;
  import qudn_pkg::*;

  // Input accept to m_axis_tvalid, through the block's registered stages.
  localparam int PIPE_LATENCY = 20;
  // Percent of cycles in which each side idles outside the steady stretch.
  localparam int IDLE_PCT     = 19;
  localparam int RANDOM_ITEMS = 800;
  // Items sent with no idling on either side.
  localparam int STEADY_FIRST = 300;
  localparam int STEADY_LAST  = 449;
  // Item before which the sender holds off until the pipe has drained.
  localparam int DRAIN_ITEM   = 600;

  // One beat of either stream: lane 0 (x) in the low bits, then y, z, w.
  typedef logic [LANES-1:0][CODE_W-1:0] quat_beat_t;

  // Keeps the expected unit quaternions and compares the output beats with them.
  class unit_quat_board;
    quat_beat_t pending_units[$];
    int         mismatches   = 0;
    int         codes_seen   = 0;
    int         results_seen = 0;

    // Magnitude of round(32768 * mag / sqrt(sumsq)), half away from zero.
    // Binary search on n: keep n when (2n-1)^2 * sumsq <= mag^2 * 2^32.
    function automatic logic [16:0] scaled_mag(input logic [MAG_W-1:0] mag,
                                               input logic [S_W-1:0] sumsq);
      logic [95:0] target;
      logic [95:0] probe;
      logic [95:0] odd;
      logic [95:0] wide_s;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      target = {80'd0, mag};
      target = (target * target) << 32;
      wide_s = {62'd0, sumsq};
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        odd = 96'(2 * mid - 1);
        probe = odd * odd * wide_s;
        if (probe <= target) lo = mid;
        else hi = mid - 1;
      end
      return 17'(lo);
    endfunction

    function automatic quat_beat_t predict_units(input quat_beat_t codes);
      quat_beat_t  units;
      logic        neg [LANES];
      logic [16:0] mag [LANES];
      logic [S_W-1:0] sumsq;
      logic [16:0] n;
      sumsq = '0;
      // v = 2u - 65535 is odd, so code 32767 is -1 and 32768 is +1
      for (int i = 0; i < LANES; i++) begin
        neg[i] = (codes[i] < 16'd32768);
        mag[i] = neg[i] ? (17'd65535 - {codes[i], 1'b0})
                        : ({codes[i], 1'b0} - 17'd65535);
        sumsq  = sumsq + S_W'(mag[i]) * S_W'(mag[i]);
      end
      for (int i = 0; i < LANES; i++) begin
        n = scaled_mag(mag[i][MAG_W-1:0], sumsq);
        if (neg[i]) units[i] = 16'(-n);           // -32768 fits as is
        else if (n > 17'd32767) units[i] = UNIT_MAX;  // +1.0 saturates
        else units[i] = n[15:0];
      end
      return units;
    endfunction

    function void note_codes(input quat_beat_t codes);
      codes_seen++;
      pending_units.push_back(predict_units(codes));
    endfunction

    function void check_units(input quat_beat_t got);
      quat_beat_t want;
      string      tags;
      tags = "xyzw";
      results_seen++;
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_units.pop_front();
      for (int i = 0; i < LANES; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: unit_%c mismatch, expected %0d, actual %0d", $time, tags[i],
                   $signed(want[i]), $signed(got[i]));
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_units.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;   // code_x, code_y, code_z, code_w
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;   // unit_x, unit_y, unit_z, unit_w

  // Set by the sender while it is in the no-idle stretch; the sink follows it.
  logic           steady;
  unit_quat_board board;

  quat_unorm16_dequant_normalize i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic quat_beat_t pack_codes(input logic [15:0] x, input logic [15:0] y,
                                            input logic [15:0] z, input logic [15:0] w);
    quat_beat_t b;
    b[0] = x;
    b[1] = y;
    b[2] = z;
    b[3] = w;
    return b;
  endfunction

  // One code per lane; the mix favors small magnitudes and extremes, where
  // rounding and saturation live, next to plain uniform codes.
  function automatic logic [15:0] rand_code(input int unsigned style);
    int unsigned k;
    case (style)
      0: return 16'($urandom_range(65535));
      1: begin
        k = $urandom_range(255);
        return 16'($urandom_range(32767 + k, 32768 - k));
      end
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(32767, 32768));
    endcase
  endfunction

  function automatic quat_beat_t rand_quat();
    quat_beat_t  b;
    int unsigned pick;
    int unsigned lead;
    pick = $urandom_range(99);
    lead = $urandom_range(LANES - 1);
    for (int i = 0; i < LANES; i++) begin
      if (pick < 45) b[i] = rand_code(0);
      else if (pick < 60) b[i] = rand_code(1);
      // one lane uniform or at full scale, the rest mostly near zero: saturation region
      else if (pick < 80) b[i] = (i == lead) ? rand_code($urandom_range(2) == 0 ? 0 : 2)
                                             : rand_code($urandom_range(1, 3));
      else b[i] = rand_code($urandom_range(3));
    end
    return b;
  endfunction

  // Present one beat, idling at random first, and hold it until accepted.
  task automatic send_quat(input quat_beat_t codes);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= codes;
    do @(posedge clk); while (!s_axis_tready);
    board.note_codes(codes);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Sink: check a beat at each edge where it is taken, then pick the next
  // ready. Values read here are the ones that held at the edge.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) board.check_units(m_axis_tdata);
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    quat_beat_t directed [$];
    board = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    steady        <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all lanes at -1, at +1, at the smallest magnitudes: 16384 each in size
    directed.push_back(pack_codes(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    directed.push_back(pack_codes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed.push_back(pack_codes(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    directed.push_back(pack_codes(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // one lane at +1, the rest at +-1/65535: rounds to 32768, saturates
    directed.push_back(pack_codes(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000));
    directed.push_back(pack_codes(16'h7FFF, 16'hFFFF, 16'h8000, 16'h7FFF));
    directed.push_back(pack_codes(16'h8000, 16'h8000, 16'hFFFF, 16'h8000));
    directed.push_back(pack_codes(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF));
    // one lane at -1, the rest near zero: negative full scale, -32768
    directed.push_back(pack_codes(16'h0000, 16'h8000, 16'h8000, 16'h7FFF));
    directed.push_back(pack_codes(16'h7FFF, 16'h0000, 16'h8000, 16'h8000));
    directed.push_back(pack_codes(16'h8000, 16'h7FFF, 16'h0000, 16'h8000));
    directed.push_back(pack_codes(16'h8000, 16'h8000, 16'h7FFF, 16'h0000));
    // mixed signs at full scale, alternating bit patterns
    directed.push_back(pack_codes(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    directed.push_back(pack_codes(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    directed.push_back(pack_codes(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    directed.push_back(pack_codes(16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000));
    directed.push_back(pack_codes(16'h0001, 16'hFFFE, 16'h8001, 16'h7FFE));
    directed.push_back(pack_codes(16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000));
    foreach (directed[i]) send_quat(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == STEADY_FIRST) steady <= 1'b1;
      else if (i == STEADY_LAST + 1) steady <= 1'b0;
      if (i == DRAIN_ITEM) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      send_quat(rand_quat());
    end
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("Sent %0d quaternions (directed extremes, saturation and -1 cases, then random)",
             board.codes_seen);
    $display("Checked %0d result beats, %0d field mismatches, %0d still pending",
             board.results_seen, board.mismatches, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("quat_unorm16_dequant_normalize_tb: done, clean");
    end else begin
      $display("quat_unorm16_dequant_normalize_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending", board.pending());
    $display("quat_unorm16_dequant_normalize_tb: done, errors");
    $finish;
  end

endmodule
